/* rtl/core/shab_pkg.sv */
// ---------------------------------------------------------------------------
// SHA-256 byte stream hasher package
// Shared constants, round constants, state types and the core control struct.
// ---------------------------------------------------------------------------
`default_nettype none

package shab_pkg;

	localparam int BYTE_COUNT_BITS = 61;
	localparam int LEN_BITS        = 64;

	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam logic [5:0] LAST_ZERO  = 6'd55;
	localparam logic [5:0] BLOCK_LAST = 6'd63;
	localparam logic [2:0] WORD_LAST  = 3'd7;
	localparam logic [5:0] ROUND_LAST = 6'd63;

	localparam logic [31:0] H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef logic [7:0][31:0] hash_words_t;

	typedef enum logic [1:0] {
		TOP_IDLE,
		TOP_HASH,
		TOP_PAD,
		TOP_OUT
	} top_state_t;

	typedef enum logic [1:0] {
		PAD_MARK,
		PAD_ZERO,
		PAD_LEN
	} pad_phase_t;

	typedef enum logic [1:0] {
		CORE_IDLE,
		CORE_ROUND,
		CORE_SUM
	} core_state_t;

	typedef struct packed {
		logic       wr_en;
		logic [5:0] wr_addr;
		logic [7:0] wr_byte;
		logic       start;
		logic       init;
	} core_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/shab_core.sv */
// ---------------------------------------------------------------------------
// SHA-256 compression core
// Holds the block as a sixteen-word schedule window, runs one round per cycle
// and folds the working variables into the chaining value at the end.
// ---------------------------------------------------------------------------
`default_nettype none

module shab_core (
	input  wire                    clk,
	input  wire                    arst_n,
	input  shab_pkg::core_ctl_t    ctl,
	output logic                   done,
	output shab_pkg::hash_words_t  hash
);

	function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
		rotr = (v >> n) | (v << (32 - n));
	endfunction

	shab_pkg::core_state_t state_q, state_d;
	logic [5:0]  rnd_q;
	logic [31:0] sched_q [16];
	logic [31:0] v_q [8];
	logic [31:0] h_q [8];

	logic [31:0] w_new, s0, s1, big0, big1, ch, maj, t1, t2;

	always_comb begin
		s0    = rotr(sched_q[1], 7) ^ rotr(sched_q[1], 18) ^ (sched_q[1] >> 3);
		s1    = rotr(sched_q[14], 17) ^ rotr(sched_q[14], 19) ^ (sched_q[14] >> 10);
		w_new = sched_q[0] + s0 + sched_q[9] + s1;
		big1  = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
		ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1    = v_q[7] + big1 + ch + shab_pkg::ROUND_K[rnd_q] + sched_q[0];
		big0  = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
		maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2    = big0 + maj;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			shab_pkg::CORE_IDLE: begin
				if (ctl.start) state_d = shab_pkg::CORE_ROUND;
			end
			shab_pkg::CORE_ROUND: begin
				if (rnd_q == shab_pkg::ROUND_LAST) state_d = shab_pkg::CORE_SUM;
			end
			shab_pkg::CORE_SUM: begin
				state_d = shab_pkg::CORE_IDLE;
			end
			default: begin
				state_d = shab_pkg::CORE_IDLE;
			end
		endcase
	end

	always_comb begin
		done = (state_q == shab_pkg::CORE_SUM);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= shab_pkg::CORE_IDLE;
			rnd_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == shab_pkg::CORE_ROUND) rnd_q <= rnd_q + 6'd1;
			else rnd_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == shab_pkg::CORE_ROUND) begin
			for (int i = 0; i < 15; i++) sched_q[i] <= sched_q[i + 1];
			sched_q[15] <= w_new;
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
		end else begin
			if (ctl.wr_en) begin
				sched_q[ctl.wr_addr[5:2]][{~ctl.wr_addr[1:0], 3'b000} +: 8] <= ctl.wr_byte;
			end
			if (ctl.start) begin
				for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) h_q[i] <= shab_pkg::H_INIT[i];
		end else if (state_q == shab_pkg::CORE_SUM) begin
			for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
		end else if (ctl.init) begin
			for (int i = 0; i < 8; i++) h_q[i] <= shab_pkg::H_INIT[i];
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) hash[i] = h_q[i];
	end

endmodule

`default_nettype wire

/* rtl/core/sha256_byte_stream_hasher.sv */
// ---------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Collects message bytes into 64-byte blocks, pads the message at its end
// and streams out the eight digest words.
// ---------------------------------------------------------------------------
//
// Channel   Direction  Payload                                   Marker
// s_axis    in         tdata: data_byte[7:0]; tuser: byte_present tlast: message_end
// m_axis    out        tdata: digest_word, word_number           tlast: last_word
//
// A byte that does not fill a block leaves the hasher ready for the next byte.
// A byte that completes a block starts 64 rounds of the shared round unit and
// a fold into the chaining value; no byte is taken meanwhile. At message end,
// 9 to 72 pad bytes go in one per cycle with one or two compressions, then
// eight words leave at the pace of m_axis_tready. Reset clears all control
// state and loads the initial hash; s_axis_tready is high only while idle.
//
`default_nettype none

module sha256_byte_stream_hasher (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  wire         s_axis_tuser,  // [0] byte_present
	input  wire         s_axis_tlast,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [31:0] digest_word, [34:32] word_number, zero fill
	output logic        m_axis_tlast
);

	shab_pkg::top_state_t state_q, state_d;
	shab_pkg::pad_phase_t phase_q;
	shab_pkg::core_ctl_t  ctl;
	shab_pkg::hash_words_t hash;

	logic [5:0]  fill_q;
	logic [shab_pkg::BYTE_COUNT_BITS-1:0] count_q;
	logic        fin_q;
	logic        pad_done_q;
	logic [2:0]  len_idx_q;
	logic [2:0]  word_q;
	logic        m_valid_q;
	logic [39:0] m_data_q;
	logic        m_last_q;

	logic        core_done;
	logic        acc;
	logic        push_en;
	logic [7:0]  push_byte;
	logic        out_load;
	logic        init;
	logic [shab_pkg::LEN_BITS-1:0] len_bits;

	shab_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.done   (core_done),
		.hash   (hash)
	);

	assign len_bits = shab_pkg::LEN_BITS'({count_q, 3'b000});
	assign acc      = s_axis_tvalid && s_axis_tready;

	always_comb begin
		s_axis_tready = 1'b0;
		push_en       = 1'b0;
		push_byte     = s_axis_tdata;
		out_load      = 1'b0;
		unique case (state_q)
			shab_pkg::TOP_IDLE: begin
				s_axis_tready = 1'b1;
				push_en       = s_axis_tvalid && s_axis_tuser;
			end
			shab_pkg::TOP_PAD: begin
				push_en = 1'b1;
				unique case (phase_q)
					shab_pkg::PAD_MARK: push_byte = shab_pkg::PAD_BYTE;
					shab_pkg::PAD_LEN:  push_byte = len_bits[{~len_idx_q, 3'b000} +: 8];
					default:            push_byte = 8'h00;
				endcase
			end
			shab_pkg::TOP_OUT: begin
				out_load = !m_valid_q || m_axis_tready;
			end
			default: begin
			end
		endcase
		init          = out_load && (word_q == shab_pkg::WORD_LAST);
		ctl.wr_en     = push_en;
		ctl.wr_addr   = fill_q;
		ctl.wr_byte   = push_byte;
		ctl.start     = push_en && (fill_q == shab_pkg::BLOCK_LAST);
		ctl.init      = init;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			shab_pkg::TOP_IDLE: begin
				if (acc) begin
					if (s_axis_tuser && fill_q == shab_pkg::BLOCK_LAST) state_d = shab_pkg::TOP_HASH;
					else if (s_axis_tlast) state_d = shab_pkg::TOP_PAD;
				end
			end
			shab_pkg::TOP_HASH: begin
				if (core_done) begin
					if (fin_q && pad_done_q) state_d = shab_pkg::TOP_OUT;
					else if (fin_q) state_d = shab_pkg::TOP_PAD;
					else state_d = shab_pkg::TOP_IDLE;
				end
			end
			shab_pkg::TOP_PAD: begin
				if (fill_q == shab_pkg::BLOCK_LAST) state_d = shab_pkg::TOP_HASH;
			end
			shab_pkg::TOP_OUT: begin
				if (init) state_d = shab_pkg::TOP_IDLE;
			end
			default: begin
				state_d = shab_pkg::TOP_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= shab_pkg::TOP_IDLE;
			phase_q    <= shab_pkg::PAD_MARK;
			fill_q     <= '0;
			count_q    <= '0;
			fin_q      <= 1'b0;
			pad_done_q <= 1'b0;
			len_idx_q  <= '0;
			word_q     <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (push_en) fill_q <= fill_q + 6'd1;
			if (init) count_q <= '0;
			else if (acc && s_axis_tuser) count_q <= count_q + 1'b1;
			if (acc) begin
				fin_q      <= s_axis_tlast;
				phase_q    <= shab_pkg::PAD_MARK;
				pad_done_q <= 1'b0;
				len_idx_q  <= '0;
			end else if (init) begin
				fin_q <= 1'b0;
			end else if (state_q == shab_pkg::TOP_PAD) begin
				unique case (phase_q)
					shab_pkg::PAD_MARK, shab_pkg::PAD_ZERO: begin
						phase_q <= (fill_q == shab_pkg::LAST_ZERO) ? shab_pkg::PAD_LEN
							: shab_pkg::PAD_ZERO;
					end
					shab_pkg::PAD_LEN: begin
						len_idx_q <= len_idx_q + 3'd1;
						if (len_idx_q == shab_pkg::WORD_LAST) pad_done_q <= 1'b1;
					end
					default: begin
						phase_q <= shab_pkg::PAD_MARK;
					end
				endcase
			end
			if (out_load) begin
				word_q    <= word_q + 3'd1;
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= {5'd0, word_q, hash[word_q]};
			m_last_q <= (word_q == shab_pkg::WORD_LAST);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;

endmodule

`default_nettype wire
